### design/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### design/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 engine.
// ----------------------------------------------------------------------------
`default_nettype none
package md5_pkg;

    localparam int BlockWords = 16;
    localparam int WordWidth  = 32;

    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hefcdab89;
    localparam logic [31:0] InitC = 32'h98badcfe;
    localparam logic [31:0] InitD = 32'h10325476;
    localparam logic [7:0]  PadByte = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_OUT
    } ctl_state_t;

    // core control reported by the round unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word index used by round i
    function automatic logic [3:0] round_g(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

### design/md5_hash_engine_top.sv
// ----------------------------------------------------------------------------
// md5_hash_engine_top
// MD5 digest over a byte stream, one result transaction per message.
// ----------------------------------------------------------------------------
// A byte transaction is accepted only in the idle state; every 64th byte starts
// a compression (one round per cycle on the shared round unit, message words
// read ahead from the 16-word block RAM through its registered read). A last
// transaction adds padding (zero words up to the end of the block) and one or
// two compressions, then holds the digest on the master side until it is taken.
`default_nettype none
module md5_hash_engine_top
    import md5_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic [1:0]   s_tuser,   // byte_valid, last_item
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [127:0] m_tdata    // digest_a, digest_b, digest_c, digest_d
);
    logic        mem_we;
    logic [3:0]  mem_waddr, mem_raddr;
    logic [31:0] mem_wdata, mem_rdata;
    logic        core_start, clear_chain;
    core_ctl_t   core;
    logic [31:0] ca, cb, cc, cd;

    md5_ram #(.Width(WordWidth), .Depth(BlockWords)) u_ram (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    md5_round u_round (
        .clk(clk), .rst_n(rst_n), .start(core_start), .clear_chain(clear_chain),
        .mem_rdata(mem_rdata), .mem_raddr(mem_raddr), .ctl(core),
        .chain_a(ca), .chain_b(cb), .chain_c(cc), .chain_d(cd)
    );

    md5_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .in_bvalid(s_tuser[0]), .in_last(s_tuser[1]),
        .out_valid(m_tvalid), .out_ready(m_tready), .core(core),
        .core_start(core_start), .clear_chain(clear_chain), .mem_we(mem_we),
        .mem_waddr(mem_waddr), .mem_wdata(mem_wdata)
    );

    assign m_tdata = {cd, cc, cb, ca};
endmodule
`default_nettype wire

### design/md5_ram.sv
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### design/md5_round.sv
// ----------------------------------------------------------------------------
// md5_round
// Iterative MD5 compression: one round per cycle, message word read from RAM.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module md5_round
    import md5_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        clear_chain,
    input  wire logic [31:0] mem_rdata,
    output logic      [3:0]  mem_raddr,
    output core_ctl_t        ctl,
    output logic      [31:0] chain_a,
    output logic      [31:0] chain_b,
    output logic      [31:0] chain_c,
    output logic      [31:0] chain_d
);
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] ha_reg, hb_reg, hc_reg, hd_reg;
    logic [5:0]  rnd_reg;     // round whose word is in mem_rdata
    logic        run_reg;     // rounds in progress
    logic        fetch_reg;   // first word being fetched
    logic        done_reg;
    logic [5:0]  rnd_next;
    logic [31:0] f, t, rot;
    logic [4:0]  s;

    // fetch word for next round in the cycle before it is used
    assign rnd_next  = fetch_reg ? 6'd0 : 6'(rnd_reg + 6'd1);
    assign mem_raddr = start ? 4'd0 : round_g(run_reg ? 6'(rnd_reg + 6'd1) : 6'd0);

    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        s   = round_s(rnd_reg);
        t   = a_reg + f + mem_rdata + round_k(rnd_reg);
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            fetch_reg <= 1'b0;
            done_reg  <= 1'b0;
            rnd_reg   <= '0;
            ha_reg    <= InitA;
            hb_reg    <= InitB;
            hc_reg    <= InitC;
            hd_reg    <= InitD;
        end
        else
        begin
            done_reg <= 1'b0;
            if (clear_chain)
            begin
                ha_reg <= InitA;
                hb_reg <= InitB;
                hc_reg <= InitC;
                hd_reg <= InitD;
            end
            if (start)
            begin
                fetch_reg <= 1'b1;
                rnd_reg   <= '0;
            end
            else if (fetch_reg)
            begin
                fetch_reg <= 1'b0;
                run_reg   <= 1'b1;
                rnd_reg   <= rnd_next;
            end
            else if (run_reg)
            begin
                if (rnd_reg == 6'd63)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                    ha_reg   <= ha_reg + d_reg;
                    hb_reg   <= hb_reg + b_reg + rot;
                    hc_reg   <= hc_reg + b_reg;
                    hd_reg   <= hd_reg + c_reg;
                end
                rnd_reg <= rnd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= ha_reg;
            b_reg <= hb_reg;
            c_reg <= hc_reg;
            d_reg <= hd_reg;
        end
        else if (run_reg)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = run_reg | fetch_reg;
    assign ctl.done  = done_reg;
    assign chain_a = ha_reg;
    assign chain_b = hb_reg;
    assign chain_c = hc_reg;
    assign chain_d = hd_reg;

    `ASSERT_IMPL(a_no_restart, clk, rst_n, start, !(run_reg || fetch_reg), "start while busy")
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg && !run_reg, "done not a pulse")
    `ASSERT_IMPL(a_fetch_excl, clk, rst_n, fetch_reg, !run_reg, "fetch overlaps rounds")
endmodule
`default_nettype wire

### design/md5_ctrl.sv
// ----------------------------------------------------------------------------
// md5_ctrl
// Byte packing, padding, length bookkeeping and sequencing of compressions.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module md5_ctrl
    import md5_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_bvalid,
    input  wire logic        in_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire core_ctl_t   core,
    output logic             core_start,
    output logic             clear_chain,
    output logic             mem_we,
    output logic      [3:0]  mem_waddr,
    output logic      [31:0] mem_wdata
);
    ctl_state_t  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [31:0] word_reg, word_next;    // partial word being assembled
    logic        last_reg, last_next;    // padding pending after this compress
    logic        lenblk_reg, lenblk_next; // current compress is the final one
    logic [3:0]  pw_reg, pw_next;        // pad word pointer
    logic        out_reg, out_next;
    logic        padding_reg;
    logic        pad2_needed;
    logic [31:0] merged;
    logic [1:0]  bpos;

    assign bpos = fill_reg[1:0];

    // first pad block done without length: a second block is required
    assign pad2_needed = (pw_reg == 4'd0) && !last_reg && fill_reg == 6'd0 && padding_reg;

    always_comb
    begin
        merged = word_reg;
        case (bpos)
            2'd0: merged = {24'd0, in_byte};
            2'd1: merged[15:8]  = in_byte;
            2'd2: merged[23:16] = in_byte;
            default: merged[31:24] = in_byte;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            bits_reg   <= '0;
            last_reg   <= 1'b0;
            lenblk_reg <= 1'b0;
            pw_reg     <= '0;
            out_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            last_reg   <= last_next;
            lenblk_reg <= lenblk_next;
            pw_reg     <= pw_next;
            out_reg    <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        word_next   = word_reg;
        last_next   = last_reg;
        lenblk_next = lenblk_reg;
        pw_next     = pw_reg;
        out_next    = out_reg;
        in_ready    = 1'b0;
        core_start  = 1'b0;
        clear_chain = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = fill_reg[5:2];
        mem_wdata   = merged;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_bvalid)
                    begin
                        word_next = merged;
                        mem_we    = 1'b1;
                        fill_next = 6'(fill_reg + 6'd1);
                        bits_next = bits_reg + 64'd8;
                    end
                    last_next = in_last;
                    if (in_bvalid && fill_reg == 6'd63)
                    begin
                        core_start  = 1'b1;
                        lenblk_next = 1'b0;
                        state_next  = ST_ROUND;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (core.done)
                begin
                    if (lenblk_reg)
                    begin
                        out_next   = 1'b1;
                        state_next = ST_OUT;
                    end
                    else if (last_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                // write 0x80 into the partial word, then zero the rest
                mem_we    = 1'b1;
                mem_waddr = fill_reg[5:2];
                case (bpos)
                    2'd0: mem_wdata = {24'd0, PadByte};
                    2'd1: mem_wdata = {16'd0, PadByte, word_reg[7:0]};
                    2'd2: mem_wdata = {8'd0, PadByte, word_reg[15:0]};
                    default: mem_wdata = {PadByte, word_reg[23:0]};
                endcase
                last_next = 1'b0;
                pw_next   = 4'(fill_reg[5:2] + 4'd1);
                fill_next = '0;
                lenblk_next = (fill_reg < 6'd56);
                state_next  = ST_FINAL;
                if (fill_reg[5:2] == 4'd15)
                begin
                    // pad byte lands in the last word: compress right away
                    core_start = 1'b1;
                    pw_next    = 4'd0;
                    state_next = ST_ROUND;
                end
            end
            ST_FINAL:
            begin
                // fill zero words up to the end of the block; length in 14/15 of the last block
                mem_we    = 1'b1;
                mem_waddr = pw_reg;
                mem_wdata = '0;
                if (lenblk_reg && pw_reg == 4'd14)
                begin
                    mem_wdata = bits_reg[31:0];
                end
                else if (lenblk_reg && pw_reg == 4'd15)
                begin
                    mem_wdata = bits_reg[63:32];
                end
                pw_next = 4'(pw_reg + 4'd1);
                if (pw_reg == 4'd15)
                begin
                    core_start = 1'b1;
                    state_next = ST_ROUND;
                    if (!lenblk_reg)
                    begin
                        // second block: only zeros and length
                        last_next = 1'b0;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    out_next    = 1'b0;
                    clear_chain = 1'b1;
                    fill_next   = '0;
                    bits_next   = '0;
                    lenblk_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // after a pad block without room for the length, build the length-only block
        if (state_reg == ST_ROUND && core.done && !lenblk_reg && pad2_needed)
        begin
            lenblk_next = 1'b1;
            pw_next     = 4'd0;
            state_next  = ST_FINAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            padding_reg <= 1'b0;
        end
        else if (state_reg == ST_PAD)
        begin
            padding_reg <= 1'b1;
        end
        else if (state_reg == ST_ROUND && core.done)
        begin
            padding_reg <= 1'b0;
        end
    end

    assign out_valid = out_reg;

    `ASSERT_IMPL(a_out_state, clk, rst_n, out_reg, state_reg == ST_OUT, "output outside ST_OUT")
    `ASSERT_IMPL(a_busy_round, clk, rst_n, core.busy, state_reg == ST_ROUND, "core busy out of round")
    `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, !out_reg, "input taken with digest pending")
endmodule
`default_nettype wire

### verif/md5_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_digest_checker
// Watches the byte and digest streams of the MD5 engine, computes the digest
// of each message on its own and compares it with every digest transaction.
// ----------------------------------------------------------------------------
module md5_digest_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    output int           err_count,
    output int           digests_pending,
    output int           digests_seen
);

    logic [31:0]  chain [4];
    logic [31:0]  blk [16];
    logic [5:0]   fill;
    logic [63:0]  msg_bits;
    logic [127:0] digest_q [$];

    localparam logic [31:0] SineK [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int Shift [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                  6, 10, 15, 21};

    task automatic new_message();
        chain[0] = 32'h67452301;
        chain[1] = 32'hefcdab89;
        chain[2] = 32'h98badcfe;
        chain[3] = 32'h10325476;
        fill = '0;
        msg_bits = '0;
    endtask

    task automatic set_byte(input int pos, input logic [7:0] b);
        blk[pos / 4][(pos % 4) * 8 +: 8] = b;
    endtask

    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, t, tmp;
        int g, s;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            s = Shift[(i / 16) * 4 + i % 4];
            t = a + f + blk[g] + SineK[i];
            tmp = d; d = c; c = b;
            b = b + ((t << s) | (t >> (32 - s)));
            a = tmp;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic absorb(input logic [7:0] data, input logic [1:0] user);
        int pos;
        if (user[0])
        begin
            set_byte(int'(fill), data);
            fill = 6'(fill + 6'd1);
            msg_bits = msg_bits + 64'd8;
            if (fill == 6'd0)
                md5_compress();
        end
        if (user[1])
        begin
            pos = int'(fill);
            set_byte(pos, 8'h80);
            pos++;
            if (pos > 56)
            begin
                while (pos < 64) begin set_byte(pos, 8'h00); pos++; end
                md5_compress();
                pos = 0;
            end
            while (pos < 56) begin set_byte(pos, 8'h00); pos++; end
            blk[14] = msg_bits[31:0];
            blk[15] = msg_bits[63:32];
            md5_compress();
            digest_q.push_back({chain[3], chain[2], chain[1], chain[0]});
            new_message();
        end
    endtask

    initial
    begin
        err_count = 0;
        digests_seen = 0;
        digests_pending = 0;
        for (int i = 0; i < 16; i++) blk[i] = '0;
        new_message();
    end

    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                absorb(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
            begin
                digests_seen++;
                if (digest_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected digest %h", $time, m_tdata);
                end
                else
                begin
                    want = digest_q.pop_front();
                    for (int w = 0; w < 4; w++)
                        if (want[w * 32 +: 32] !== m_tdata[w * 32 +: 32])
                        begin
                            err_count++;
                            $display("%0t: digest word %0d expected %h actual %h",
                                     $time, w, want[w * 32 +: 32], m_tdata[w * 32 +: 32]);
                        end
                end
            end
            digests_pending = digest_q.size();
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives messages of random length and content into the MD5 engine with
// random gaps and back-pressure; the checker predicts and compares digests.
// ----------------------------------------------------------------------------
module tb;

    localparam int IdleLimit = 5000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic [1:0]   s_tuser;   // byte_valid, last_item
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // digest_a, digest_b, digest_c, digest_d
    int           err_count;
    int           digests_pending;
    int           digests_seen;
    int           send_idle;
    int           recv_idle;
    int           idle_cycles = 0;
    int           items_sent;

    md5_hash_engine_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    md5_digest_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .err_count(err_count), .digests_pending(digests_pending),
        .digests_seen(digests_seen)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // sink back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    // watchdog on cycles with no accepted transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] data, input logic valid_byte,
                             input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= {last, valid_byte};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_message(input int len, input int mode);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: b = 8'($urandom);
                1: b = 8'hff;
                default: b = 8'h00;
            endcase
            // occasional empty item inside a message
            if ($urandom_range(19) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(b, 1'b1, (i == len - 1) && $urandom_range(1));
            if (i == len - 1 && s_tuser[1] == 1'b0)
                send_item(8'($urandom), 1'b0, 1'b1);
        end
        if (len == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(9);
        if (r < 5) return $urandom_range(70);
        if (r < 8) return 52 + $urandom_range(16);
        return $urandom_range(200);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        items_sent = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty, tiny, padding boundaries, full blocks, extremes
        send_message(0, 0);
        send_item(8'h61, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_message(3, 1);
        send_message(2, 2);
        send_message(0, 0);
        send_message(1, 1);
        send_message(1, 2);
        send_message(1, 0);
        send_message(1, 0);
        send_message(1, 0);
        send_message(1, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 11 : (ph == 1) ? 74 : 0;
            recv_idle = (ph == 0) ? 74 : (ph == 1) ? 11 : 0;
            if (ph == 0)
            begin
                send_message(55, 0);
                send_message(56, 0);
                send_message(63, 0);
                send_message(64, 1);
                send_message(119, 0);
                send_message(128, 2);
            end
            while (items_sent < 430 * (ph + 1))
                send_message(pick_len(), ($urandom_range(15) == 0) ? 1 : 0);
        end
        s_tvalid <= 1'b0;

        while (digests_pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        $display("tb: %0d transactions sent, %0d digests checked, messages of 0..200 bytes",
                 items_sent, digests_seen);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/md5_pkg.sv
design/md5_ram.sv
design/md5_round.sv
design/md5_ctrl.sv
design/md5_hash_engine_top.sv
verif/md5_digest_checker.sv
verif/tb.sv
